[rtl/core/tsq_pkg.sv]
// Shared types, register codes and reset values for the temperature qualifier.
`default_nettype none

package tsq_pkg;

  localparam int TEMP_W     = 12;
  localparam int FAIL_W     = 8;
  localparam int NSENS      = 3;
  localparam int WINDOW_DEF = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 2'd3;

  localparam logic signed [TEMP_W-1:0] VALID_MIN_RST  = -12'sd880;
  localparam logic signed [TEMP_W-1:0] VALID_MAX_RST  = 12'sd2000;
  localparam logic        [TEMP_W-1:0] MAX_STEP_RST   = 12'd80;
  localparam logic        [FAIL_W-1:0] FAIL_LIMIT_RST = 8'd3;
  localparam logic signed [TEMP_W-1:0] HELD_RST       = 12'sd400;
  localparam logic        [FAIL_W-1:0] FAIL_SAT       = 8'd255;

  typedef struct packed {
    logic signed [TEMP_W-1:0] reading_a;
    logic signed [TEMP_W-1:0] reading_b;
    logic signed [TEMP_W-1:0] reading_c;
    logic                     ok_a;
    logic                     ok_b;
    logic                     ok_c;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] filtered_a;
    logic signed [TEMP_W-1:0] filtered_b;
    logic signed [TEMP_W-1:0] filtered_c;
    logic signed [TEMP_W-1:0] control_temp;
    logic        [2:0]        accepted;
    logic                     degraded;
    logic                     fault;
  } out_t;

endpackage

`default_nettype wire

[rtl/core/tsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 24,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tsq_div.sv]
// Bit-serial restoring divider for signed means, quotient truncated toward zero.
`default_nettype none

module tsq_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             neg,
  input  wire logic [DVD_W-1:0]                 dividend,
  input  wire logic [DVS_W-1:0]                 divisor,
  output logic                                  done,
  output logic signed [tsq_pkg::TEMP_W-1:0]     quot
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = neg;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(quo_r[tsq_pkg::TEMP_W-1:0])
                      : $signed(quo_r[tsq_pkg::TEMP_W-1:0]);

endmodule

`default_nettype wire

[rtl/core/triple_sensor_temperature_qualifier.sv]
// Top level: three-sensor plausibility check, window means and control temperature.
`default_nettype none

// One in beat carries an update of three sensors and yields one out beat. The
// sensors are handled in turn: a check cycle writes an accepted reading into
// the shared sample RAM, the window is then read back one entry per cycle
// through the RAM's single read port, and a bit-serial divider with a
// dividend of SUM_W = 12 + clog2(WINDOW + 1) bits forms the mean. A last
// division averages the qualifying sensors. The next in beat is taken as soon
// as the result sits in the output register, even while out_stall holds it
// there.
module triple_sensor_temperature_qualifier #(
  parameter int WINDOW = tsq_pkg::WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire tsq_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tsq_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tsq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [tsq_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int TW     = tsq_pkg::TEMP_W;
  localparam int FW     = tsq_pkg::FAIL_W;
  localparam int DEPTH  = 3 * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = TW + $clog2(WINDOW + 1);
  localparam int DVS_W  = (CNT_W < 2) ? 2 : CNT_W;
  localparam int CS_W   = TW + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SDIV = 3'd3;
  localparam logic [2:0] ST_CTL  = 3'd4;
  localparam logic [2:0] ST_CDIV = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic signed [TW-1:0] vmin_r, vmax_r;
  logic        [TW-1:0] step_r;
  logic        [FW-1:0] flim_r;

  tsq_pkg::in_t  item_r, item_nxt;
  tsq_pkg::out_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]     wp_r   [3];
  logic [IDX_W-1:0]     wp_nxt [3];
  logic [CNT_W-1:0]     fill_r   [3];
  logic [CNT_W-1:0]     fill_nxt [3];
  logic [FW-1:0]        fail_r   [3];
  logic [FW-1:0]        fail_nxt [3];
  logic                 seen_r   [3];
  logic                 seen_nxt [3];
  logic signed [TW-1:0] last_r   [3];
  logic signed [TW-1:0] last_nxt [3];
  logic signed [TW-1:0] filt_r   [3];
  logic signed [TW-1:0] filt_nxt [3];
  logic signed [TW-1:0] held_r, held_nxt;

  logic [1:0]              sidx_r, sidx_nxt;
  logic [2:0]              mask_r, mask_nxt;
  logic [1:0]              qcnt_r, qcnt_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, base;
  logic [TW-1:0]     ram_rdata;

  logic                 div_start, div_neg, div_done;
  logic [SUM_W-1:0]     div_dvd;
  logic [DVS_W-1:0]     div_dvs;
  logic signed [TW-1:0] div_quot;

  logic signed [TW-1:0] t_sel;
  logic                 ok_sel;
  logic signed [TW:0]   diff;
  logic        [TW:0]   absd;
  logic                 accept;
  logic [CNT_W-1:0]     n_cur;
  logic [SUM_W-1:0]     acc_mag;
  logic [2:0]           qual;
  logic signed [CS_W-1:0] csum;
  logic        [CS_W-1:0] cmag;

  always_comb begin
    case (sidx_r)
      2'd0: begin
        t_sel  = item_r.reading_a;
        ok_sel = item_r.ok_a;
      end
      2'd1: begin
        t_sel  = item_r.reading_b;
        ok_sel = item_r.ok_b;
      end
      default: begin
        t_sel  = item_r.reading_c;
        ok_sel = item_r.ok_c;
      end
    endcase
  end

  assign base  = ADDR_W'(sidx_r) * ADDR_W'(WINDOW);
  assign diff  = (TW+1)'(t_sel) - (TW+1)'(last_r[sidx_r]);
  assign absd  = diff[TW] ? (TW+1)'(-diff) : (TW+1)'(diff);
  assign accept = ok_sel && (t_sel >= vmin_r) && (t_sel <= vmax_r) &&
                  (!seen_r[sidx_r] || (step_r == '0) || (absd <= {1'b0, step_r}));
  assign n_cur   = fill_r[sidx_r];
  assign acc_mag = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      qual[s] = fail_r[s] < flim_r;
    end
  end
  assign csum = (qual[0] ? CS_W'(filt_r[0]) : CS_W'(0)) +
                (qual[1] ? CS_W'(filt_r[1]) : CS_W'(0)) +
                (qual[2] ? CS_W'(filt_r[2]) : CS_W'(0));
  assign cmag = csum[CS_W-1] ? CS_W'(-csum) : CS_W'(csum);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    fail_nxt      = fail_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    filt_nxt      = filt_r;
    held_nxt      = held_r;
    sidx_nxt      = sidx_r;
    mask_nxt      = mask_r;
    qcnt_nxt      = qcnt_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    ram_we        = 1'b0;
    ram_waddr     = base + ADDR_W'(wp_r[sidx_r]);
    ram_re        = 1'b0;
    ram_raddr     = base + ADDR_W'(rd_idx_r);
    div_start     = 1'b0;
    div_neg       = acc_r[SUM_W-1];
    div_dvd       = acc_mag;
    div_dvs       = DVS_W'(n_cur);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          sidx_nxt  = 2'd0;
          mask_nxt  = 3'b000;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (accept) begin
          ram_we           = 1'b1;
          wp_nxt[sidx_r]   = (wp_r[sidx_r] == IDX_W'(WINDOW - 1)) ? '0
                                                                  : wp_r[sidx_r] + 1'b1;
          if (fill_r[sidx_r] < CNT_W'(WINDOW)) begin
            fill_nxt[sidx_r] = fill_r[sidx_r] + 1'b1;
          end
          last_nxt[sidx_r] = t_sel;
          seen_nxt[sidx_r] = 1'b1;
          fail_nxt[sidx_r] = '0;
          mask_nxt[sidx_r] = 1'b1;
        end else if (fail_r[sidx_r] != tsq_pkg::FAIL_SAT) begin
          fail_nxt[sidx_r] = fail_r[sidx_r] + 1'b1;
        end
        rd_idx_nxt = '0;
        acc_nxt    = '0;
        state_nxt  = ST_RD;
      end
      ST_RD: begin
        if (rd_vld_r) begin
          acc_nxt = acc_r + SUM_W'($signed(ram_rdata));
        end
        if (rd_idx_r < n_cur) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          if (n_cur == '0) begin
            filt_nxt[sidx_r] = '0;
            if (sidx_r == 2'd2) begin
              state_nxt = ST_CTL;
            end else begin
              sidx_nxt  = sidx_r + 1'b1;
              state_nxt = ST_CHK;
            end
          end else begin
            div_start = 1'b1;
            state_nxt = ST_SDIV;
          end
        end
      end
      ST_SDIV: begin
        if (div_done) begin
          filt_nxt[sidx_r] = div_quot;
          if (sidx_r == 2'd2) begin
            state_nxt = ST_CTL;
          end else begin
            sidx_nxt  = sidx_r + 1'b1;
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CTL: begin
        qcnt_nxt = 2'(qual[0]) + 2'(qual[1]) + 2'(qual[2]);
        div_neg  = csum[CS_W-1];
        div_dvd  = SUM_W'(cmag);
        div_dvs  = DVS_W'(qcnt_nxt);
        if (qcnt_nxt != 2'd0) begin
          div_start = 1'b1;
          state_nxt = ST_CDIV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          held_nxt  = div_quot;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.filtered_a   = filt_r[0];
          out_nxt.filtered_b   = filt_r[1];
          out_nxt.filtered_c   = filt_r[2];
          out_nxt.control_temp = held_r;
          out_nxt.accepted     = mask_r;
          out_nxt.degraded     = qcnt_r == 2'd2;
          out_nxt.fault        = qcnt_r <= 2'd1;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= tsq_pkg::HELD_RST;
      rd_vld_r    <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        wp_r[s]   <= '0;
        fill_r[s] <= '0;
        fail_r[s] <= '0;
        seen_r[s] <= 1'b0;
        last_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      rd_vld_r    <= rd_vld_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      fail_r      <= fail_nxt;
      seen_r      <= seen_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    filt_r   <= filt_nxt;
    sidx_r   <= sidx_nxt;
    mask_r   <= mask_nxt;
    qcnt_r   <= qcnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    acc_r    <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmin_r <= tsq_pkg::VALID_MIN_RST;
      vmax_r <= tsq_pkg::VALID_MAX_RST;
      step_r <= tsq_pkg::MAX_STEP_RST;
      flim_r <= tsq_pkg::FAIL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tsq_pkg::REG_VALID_MIN:  vmin_r <= $signed(cfg_wdata[TW-1:0]);
        tsq_pkg::REG_VALID_MAX:  vmax_r <= $signed(cfg_wdata[TW-1:0]);
        tsq_pkg::REG_MAX_STEP:   step_r <= cfg_wdata[TW-1:0];
        tsq_pkg::REG_FAIL_LIMIT: flim_r <= cfg_wdata[FW-1:0];
        default: ;
      endcase
    end
  end

  tsq_ram #(
    .WIDTH (TW),
    .DEPTH (DEPTH)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (t_sel),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsq_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .neg      (div_neg),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_CHK)
    else $error("accepted beat did not start the sensor check");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_SDIV || state_r == ST_CDIV))
    else $error("divider finished outside a divide wait");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= CNT_W'(WINDOW) && fill_r[1] <= CNT_W'(WINDOW) &&
    fill_r[2] <= CNT_W'(WINDOW))
    else $error("window fill count beyond window size");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result beat raised outside the finish state");
`endif

endmodule

`default_nettype wire

[verif/tb_triple_sensor_temperature_qualifier.sv]
// Self-checking testbench for the three-sensor temperature qualifier.
`timescale 1ns / 1ps

module tb_triple_sensor_temperature_qualifier;

  localparam int WIN         = tsq_pkg::WINDOW_DEF;
  localparam int NS          = tsq_pkg::NSENS;
  localparam int TW          = tsq_pkg::TEMP_W;
  localparam int SETTLE      = 150;
  localparam int LONG_HOLD   = 2000;
  localparam int DRAIN_MAX   = 50000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_PHASE     = 5;

  typedef struct {
    tsq_pkg::in_t  beat;
    bit            fixed;
    tsq_pkg::out_t want;
  } plan_row_t;

  typedef struct {
    int lo;
    int hi;
    int step;
    int limit;
    int count;
    int span;
    bit idle;
  } phase_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  tsq_pkg::in_t                  in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  tsq_pkg::out_t                 out_data;
  logic                          cfg_we    = 1'b0;
  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [tsq_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // predictor state and register copies
  int win_buf  [NS][WIN];
  int win_wr   [NS];
  int win_fill [NS];
  int fail_cnt [NS];
  bit seen     [NS];
  int last_val [NS];
  int held_ctl = int'(tsq_pkg::HELD_RST);
  int lim_min  = int'(tsq_pkg::VALID_MIN_RST);
  int lim_max  = int'(tsq_pkg::VALID_MAX_RST);
  int lim_step = int'(tsq_pkg::MAX_STEP_RST);
  int lim_fail = int'(tsq_pkg::FAIL_LIMIT_RST);

  tsq_pkg::out_t result_q [$];
  plan_row_t     typed_q  [$];
  plan_row_t     plan     [$];
  phase_t        phases   [N_PHASE];

  int err_cnt   = 0;
  int out_cnt   = 0;
  int cycle_cnt = 0;
  bit idle_en   = 1'b1;
  bit hold_req  = 1'b0;

  triple_sensor_temperature_qualifier #(.WINDOW(WIN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // oks bit 0 is sensor a, as in the accepted bits of a result
  function automatic tsq_pkg::in_t make_beat(int ra, int rb, int rc, bit [2:0] oks);
    tsq_pkg::in_t b;
    b.reading_a = ra[TW-1:0];
    b.reading_b = rb[TW-1:0];
    b.reading_c = rc[TW-1:0];
    b.ok_a      = oks[0];
    b.ok_b      = oks[1];
    b.ok_c      = oks[2];
    return b;
  endfunction

  function automatic void add_row(int ra, int rb, int rc, bit [2:0] oks, bit fixed,
                                  tsq_pkg::out_t want);
    plan_row_t r;
    r.beat  = make_beat(ra, rb, rc, oks);
    r.fixed = fixed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic tsq_pkg::out_t qualify_update(tsq_pkg::in_t beat);
    int            rd [NS];
    bit            ok [NS];
    int            filt [NS];
    int            acc_sum;
    int            n_qual;
    int            jump;
    bit            take;
    tsq_pkg::out_t res;
    rd[0] = int'(beat.reading_a);
    rd[1] = int'(beat.reading_b);
    rd[2] = int'(beat.reading_c);
    ok[0] = beat.ok_a;
    ok[1] = beat.ok_b;
    ok[2] = beat.ok_c;
    res = '0;
    for (int s = 0; s < NS; s++) begin
      take = ok[s] && rd[s] >= lim_min && rd[s] <= lim_max;
      if (take && seen[s] && lim_step != 0) begin
        jump = rd[s] - last_val[s];
        if (jump < 0) jump = -jump;
        take = jump <= lim_step;
      end
      if (take) begin
        win_buf[s][win_wr[s]] = rd[s];
        win_wr[s] = (win_wr[s] + 1) % WIN;
        if (win_fill[s] < WIN) win_fill[s]++;
        last_val[s] = rd[s];
        seen[s] = 1'b1;
        fail_cnt[s] = 0;
        res.accepted[s] = 1'b1;
      end else if (fail_cnt[s] < int'(tsq_pkg::FAIL_SAT)) begin
        fail_cnt[s]++;
      end
      acc_sum = 0;
      for (int i = 0; i < win_fill[s]; i++) acc_sum += win_buf[s][i];
      filt[s] = (win_fill[s] == 0) ? 0 : acc_sum / win_fill[s];
    end
    acc_sum = 0;
    n_qual  = 0;
    for (int s = 0; s < NS; s++) begin
      if (fail_cnt[s] < lim_fail) begin
        acc_sum += filt[s];
        n_qual++;
      end
    end
    if (n_qual > 0) held_ctl = acc_sum / n_qual;
    res.filtered_a   = filt[0][TW-1:0];
    res.filtered_b   = filt[1][TW-1:0];
    res.filtered_c   = filt[2][TW-1:0];
    res.control_temp = held_ctl[TW-1:0];
    res.degraded     = (n_qual == 2);
    res.fault        = (n_qual <= 1);
    return res;
  endfunction

  task automatic send_beat(input plan_row_t row);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    typed_q.push_back(row);
    in_valid <= 1'b1;
    in_data  <= row.beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tsq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsq_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : beat_accept
    plan_row_t     row;
    tsq_pkg::out_t pred;
    if (rst_n && in_valid && !in_stall) begin
      row  = typed_q.pop_front();
      pred = qualify_update(in_data);
      result_q.push_back(row.fixed ? row.want : pred);
    end
  end

  always @(posedge clk) begin : result_check
    tsq_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("beat %0d: result with none expected", out_cnt);
      end else begin
        want = result_q.pop_front();
        if (out_data.filtered_a !== want.filtered_a ||
            out_data.filtered_b !== want.filtered_b ||
            out_data.filtered_c !== want.filtered_c ||
            out_data.control_temp !== want.control_temp ||
            out_data.accepted !== want.accepted ||
            out_data.degraded !== want.degraded ||
            out_data.fault !== want.fault) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("beat %0d got:  filt %0d %0d %0d ctl %0d acc %b deg %b flt %b",
                     out_cnt, out_data.filtered_a, out_data.filtered_b,
                     out_data.filtered_c, out_data.control_temp, out_data.accepted,
                     out_data.degraded, out_data.fault);
            $display("beat %0d want: filt %0d %0d %0d ctl %0d acc %b deg %b flt %b",
                     out_cnt, want.filtered_a, want.filtered_b, want.filtered_c,
                     want.control_temp, want.accepted, want.degraded, want.fault);
          end
        end
      end
      out_cnt++;
    end
  end

  // receiver pacing; one long hold fills the block and backs up the input
  initial begin : rx_pace
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    phase_t    ph;
    plan_row_t row;
    int        rd [NS];
    bit [2:0]  oks;
    int        mid;
    int        base;
    int        v;
    int        wait_cnt;

    // default registers, then extremes, inverted range, exclusion of all, then a narrow range with no idles
    phases[0] = '{-880, 2000, 80, 3, 250, 100, 1'b1};
    phases[1] = '{-2048, 2047, 0, 255, 200, 0, 1'b1};
    phases[2] = '{100, -100, 4095, 1, 300, 0, 1'b1};
    phases[3] = '{-2048, 2047, 4095, 0, 100, 300, 1'b1};
    phases[4] = '{-500, 1500, 40, 2, 350, 50, 1'b0};

    // directed part, reset register values
    add_row(400, 400, 400, 3'b000, 1'b1,
            {12'sd0, 12'sd0, 12'sd0, 12'sd0, 3'b000, 1'b0, 1'b0});
    add_row(2000, -880, 0, 3'b111, 1'b1,
            {12'sd2000, -12'sd880, 12'sd0, 12'sd373, 3'b111, 1'b0, 1'b0});
    add_row(2001, -881, 81, 3'b111, 1'b1,
            {12'sd2000, -12'sd880, 12'sd0, 12'sd373, 3'b000, 1'b0, 1'b0});
    add_row(1920, -800, 80, 3'b111, 1'b0, '0);
    add_row(-2048, 2047, 2047, 3'b111, 1'b0, '0);
    add_row(2047, -2048, -2048, 3'b000, 1'b0, '0);
    repeat (3) add_row(1900, -790, 0, 3'b011, 1'b0, '0);
    repeat (3) add_row(1880, -790, 0, 3'b001, 1'b0, '0);
    repeat (3) add_row(1880, -790, 0, 3'b000, 1'b0, '0);
    add_row(1800, -790, 80, 3'b111, 1'b0, '0);
    add_row(1719, -871, 161, 3'b111, 1'b0, '0);
    add_row(1365, -1366, 0, 3'b101, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_beat(plan[i]);

    for (int p = 0; p < N_PHASE; p++) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (result_q.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      ph = phases[p];
      write_reg(tsq_pkg::REG_VALID_MIN, tsq_pkg::CFG_W'(ph.lo));
      write_reg(tsq_pkg::REG_VALID_MAX, tsq_pkg::CFG_W'(ph.hi));
      write_reg(tsq_pkg::REG_MAX_STEP, tsq_pkg::CFG_W'(ph.step));
      write_reg(tsq_pkg::REG_FAIL_LIMIT, tsq_pkg::CFG_W'(ph.limit));
      cfg_we   <= 1'b0;
      lim_min  = ph.lo;
      lim_max  = ph.hi;
      lim_step = ph.step;
      lim_fail = ph.limit;
      idle_en  = ph.idle;
      if (p == 0) hold_req = 1'b1;
      mid = (ph.lo + ph.hi) / 2;
      for (int k = 0; k < ph.count; k++) begin
        for (int s = 0; s < NS; s++) begin
          base = (last_val[s] >= ph.lo && last_val[s] <= ph.hi) ? last_val[s] : mid;
          if (ph.span != 0 && $urandom_range(0, 15) != 0) begin
            // plausible walk around the last accepted value, drifting to mid range
            v = base + int'($urandom_range(0, 2 * ph.span)) - ph.span;
            v += (mid > base) ? ph.span / 4 : -(ph.span / 4);
            if (v > 2047) v = 2047;
            if (v < -2048) v = -2048;
            oks[s] = ($urandom_range(0, 9) != 0);
          end else begin
            v = int'($urandom_range(0, 4095)) - 2048;
            oks[s] = 1'($urandom_range(0, 1));
          end
          rd[s] = v;
        end
        row.beat  = make_beat(rd[0], rd[1], rd[2], oks);
        row.fixed = 1'b0;
        row.want  = '0;
        send_beat(row);
      end
    end

    in_valid <= 1'b0;
    wait_cnt = 0;
    while (result_q.size() != 0 && wait_cnt < DRAIN_MAX) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (SETTLE) @(posedge clk);
    err_cnt += result_q.size();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
